FILE: rtl/urb_pkg.sv
package urb_pkg;

    localparam int URB_RX_DEPTH = 32;
    localparam int URB_TX_DEPTH = 32;

    localparam logic [7:0] URB_XON  = 8'h11;
    localparam logic [7:0] URB_XOFF = 8'h13;

    typedef enum logic [2:0] {
        OP_RX_BYTE = 3'd0,
        OP_PUT     = 3'd1,
        OP_TX_RDY  = 3'd2,
        OP_READ    = 3'd3,
        OP_CLR_RX  = 3'd4
    } t_op;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
        logic clr;
    } t_ring_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_sts;

endpackage

FILE: rtl/uart_ring_buffers_xon_xoff.sv
// channel  direction  handshake              payload
// in       input      i_in_valid/o_in_stall  i_opcode, i_data_in, i_read_limit
// out      output     o_out_valid/i_out_stall o_accepted, o_byte_valid, o_byte_out,
//                                             o_last, o_tx_busy
// A read of n bytes yields n words, one word per cycle while i_out_stall is low,
// paced by the registered head read of the receive ring.
// Both rings are single-port-write memories with a prefetched head word.
// Reset is synchronous; rings come up empty and flow stopped.
// Input stalls during a multi-word read and while the output word is held.
module uart_ring_buffers_xon_xoff
    import urb_pkg::*;
#(
    parameter int RX_DEPTH = URB_RX_DEPTH,
    parameter int TX_DEPTH = URB_TX_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_data_in,
    input  logic [7:0] i_read_limit,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_accepted,
    output logic       o_byte_valid,
    output logic [7:0] o_byte_out,
    output logic       o_last,
    output logic       o_tx_busy
);

    localparam int RXW = $clog2(RX_DEPTH);
    localparam int TXW = $clog2(TX_DEPTH);

    t_ring_ctl      rx_ctl;
    t_ring_ctl      tx_ctl;
    t_ring_sts      rx_sts;
    t_ring_sts      tx_sts;
    logic [7:0]     rx_rdata;
    logic [7:0]     tx_rdata;
    logic [7:0]     tx_wdata;
    logic [RXW-1:0] rx_count;
    logic [TXW-1:0] tx_count;
    logic [7:0]     rx_cnt8;
    logic [7:0]     rd_cnt;

    t_state         r_state;
    t_state         n_state;
    logic [7:0]     r_rem;
    logic [7:0]     n_rem;
    logic           r_flow_stop;
    logic           n_flow_stop;
    logic           r_tx_active;
    logic           n_tx_active;

    logic           r_out_valid;
    logic           r_accepted;
    logic           r_byte_valid;
    logic [7:0]     r_byte_out;
    logic           r_last;
    logic           r_tx_busy;
    logic           n_accepted;
    logic           n_byte_valid;
    logic [7:0]     n_byte_out;
    logic           n_last;
    logic           load_out;
    logic           out_free;
    logic           fire;

    urb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rx_ctl),
        .i_wdata (i_data_in),
        .o_rdata (rx_rdata),
        .o_sts   (rx_sts),
        .o_count (rx_count)
    );

    urb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tx_ctl),
        .i_wdata (tx_wdata),
        .o_rdata (tx_rdata),
        .o_sts   (tx_sts),
        .o_count (tx_count)
    );

    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) | ~out_free;
    assign fire       = i_in_valid & ~o_in_stall;
    assign rx_cnt8    = 8'(rx_count);
    assign rd_cnt     = (rx_cnt8 < i_read_limit) ? rx_cnt8 : i_read_limit;

    always_comb begin
        n_state      = r_state;
        n_rem        = r_rem;
        n_flow_stop  = r_flow_stop;
        n_tx_active  = r_tx_active;
        rx_ctl       = '0;
        tx_ctl       = '0;
        tx_wdata     = i_data_in;
        load_out     = 1'b0;
        n_accepted   = 1'b0;
        n_byte_valid = 1'b0;
        n_byte_out   = '0;
        n_last       = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (fire) begin
                    load_out = 1'b1;
                    case (t_op'(i_opcode))
                        OP_RX_BYTE: begin
                            if (!rx_sts.full) begin
                                rx_ctl.push = 1'b1;
                                n_accepted  = 1'b1;
                            end else if (!r_flow_stop) begin
                                n_flow_stop = 1'b1;
                                tx_wdata    = URB_XOFF;
                                if (!tx_sts.full) begin
                                    tx_ctl.push = 1'b1;
                                    n_tx_active = 1'b1;
                                end
                            end
                        end
                        OP_PUT: begin
                            if (!tx_sts.full) begin
                                tx_ctl.push = 1'b1;
                                n_tx_active = 1'b1;
                                n_accepted  = 1'b1;
                            end
                        end
                        OP_TX_RDY: begin
                            if (!tx_sts.empty) begin
                                tx_ctl.pop   = 1'b1;
                                n_byte_valid = 1'b1;
                                n_byte_out   = tx_rdata;
                            end else begin
                                n_tx_active = 1'b0;
                            end
                        end
                        OP_READ: begin
                            if (rd_cnt != 8'd0) begin
                                rx_ctl.pop   = 1'b1;
                                n_byte_valid = 1'b1;
                                n_byte_out   = rx_rdata;
                                n_last       = (rd_cnt == 8'd1);
                                n_rem        = rd_cnt - 8'd1;
                                if (rd_cnt != 8'd1) begin
                                    n_state = S_READ;
                                end
                                // XON goes in up front; tx ring is idle during the read
                                if (r_flow_stop) begin
                                    n_flow_stop = 1'b0;
                                    tx_wdata    = URB_XON;
                                    if (!tx_sts.full) begin
                                        tx_ctl.push = 1'b1;
                                        n_tx_active = 1'b1;
                                    end
                                end
                            end
                        end
                        OP_CLR_RX: begin
                            rx_ctl.clr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    rx_ctl.pop   = 1'b1;
                    n_byte_valid = 1'b1;
                    n_byte_out   = rx_rdata;
                    n_last       = (r_rem == 8'd1);
                    n_rem        = r_rem - 8'd1;
                    if (r_rem == 8'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rem       <= '0;
            r_flow_stop <= 1'b1;
            r_tx_active <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rem       <= n_rem;
            r_flow_stop <= n_flow_stop;
            r_tx_active <= n_tx_active;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_accepted   <= n_accepted;
            r_byte_valid <= n_byte_valid;
            r_byte_out   <= n_byte_out;
            r_last       <= n_last;
            r_tx_busy    <= n_tx_active;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_accepted   = r_accepted;
    assign o_byte_valid = r_byte_valid;
    assign o_byte_out   = r_byte_out;
    assign o_last       = r_last;
    assign o_tx_busy    = r_tx_busy;

`ifndef SYNTH
    a_rx_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_ctl.pop |-> !rx_sts.empty)
        else $error("rx pop on empty ring");

    a_tx_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_ctl.push |-> !tx_sts.full)
        else $error("tx push on full ring");

    a_read_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_rem != 8'd0) && (8'(rx_count) >= r_rem))
        else $error("read count exceeds ring contents");

    a_xoff_on_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_flow_stop) && $past(i_rst_n) |-> $past(rx_sts.full))
        else $error("flow stopped without rx overflow");

    a_tx_count_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_sts.empty == (tx_count == '0))
        else $error("tx count disagrees with empty flag");
`endif

endmodule

FILE: rtl/urb_ring.sv
module urb_ring
    import urb_pkg::*;
#(
    parameter int DEPTH = URB_RX_DEPTH,
    localparam int PW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ring_ctl     i_ctl,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata,
    output t_ring_sts     o_sts,
    output logic [PW-1:0] o_count
);

    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic [PW-1:0] wp_next;
    logic [PW-1:0] rp_next;
    logic [PW:0]   diff;
    logic          push_ok;
    logic          pop_ok;
    logic [7:0]    r_rdata;

    assign wp_next = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
    assign rp_next = (r_rp == LAST_IDX) ? '0 : r_rp + 1'b1;

    assign o_sts.empty = (r_wp == r_rp);
    assign o_sts.full  = (wp_next == r_rp);
    assign push_ok     = i_ctl.push & ~o_sts.full;
    assign pop_ok      = i_ctl.pop & ~o_sts.empty;

    always_comb begin
        diff = {1'b0, r_wp} - {1'b0, r_rp};
        if (r_wp < r_rp) begin
            diff = diff + DEPTH_W;
        end
        o_count = diff[PW-1:0];
    end

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (i_ctl.clr) begin
            n_wp = '0;
            n_rp = '0;
        end else begin
            if (push_ok) begin
                n_wp = wp_next;
            end
            if (pop_ok) begin
                n_rp = rp_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // head prefetch, write-through when the head entry is written
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            mem[r_wp] <= i_wdata;
        end
        if (push_ok && (r_wp == n_rp)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= mem[n_rp];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/tb_uart_ring_buffers_xon_xoff.sv
`timescale 1ns / 1ps

module tb_uart_ring_buffers_xon_xoff;
    import urb_pkg::*;

    localparam logic [2:0] OP_BAD_LO = 3'd5;
    localparam logic [2:0] OP_BAD_HI = 3'd7;
    localparam int RANDOM_ITEMS = 320;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [7:0] limit;
    } t_op_item;

    typedef struct packed {
        logic       accepted;
        logic       byte_valid;
        logic [7:0] byte_out;
        logic       last;
        logic       tx_busy;
    } t_out_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_opcode = '0;
    logic [7:0] i_data_in = '0;
    logic [7:0] i_read_limit = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_accepted;
    logic       o_byte_valid;
    logic [7:0] o_byte_out;
    logic       o_last;
    logic       o_tx_busy;

    uart_ring_buffers_xon_xoff i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_data_in    (i_data_in),
        .i_read_limit (i_read_limit),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_accepted   (o_accepted),
        .o_byte_valid (o_byte_valid),
        .o_byte_out   (o_byte_out),
        .o_last       (o_last),
        .o_tx_busy    (o_tx_busy)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow state of both rings and the flow flags
    logic [7:0] rx_mem [URB_RX_DEPTH];
    logic [7:0] tx_mem [URB_TX_DEPTH];
    int         rx_wr, rx_rd, tx_wr, tx_rd;
    logic       flow_stopped;
    logic       tx_active;

    t_op_item   pending_ops[$];
    t_out_word  expected_words[$];
    bit         word_pending = 1'b0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         errors = 0;
    int         words_checked = 0;
    int         ops_taken = 0;
    int         op_count [8];
    int         rx_drops = 0;
    int         tx_refusals = 0;
    t_op_item   drive_item;
    t_out_word  want_word;

    function automatic int ring_next(int p, int depth);
        return (p + 1 >= depth) ? 0 : p + 1;
    endfunction

    function automatic bit tx_push(logic [7:0] b);
        if (ring_next(tx_wr, URB_TX_DEPTH) == tx_rd)
            return 1'b0;
        tx_mem[tx_wr] = b;
        tx_wr = ring_next(tx_wr, URB_TX_DEPTH);
        tx_active = 1'b1;
        return 1'b1;
    endfunction

    task automatic predict_op(input logic [2:0] op, input logic [7:0] data,
                              input logic [7:0] limit);
        t_out_word words[$];
        t_out_word w;
        int left;
        left = limit;
        w = '0;
        w.last = 1'b1;
        op_count[op]++;
        case (op)
            OP_RX_BYTE: begin
                if (ring_next(rx_wr, URB_RX_DEPTH) != rx_rd) begin
                    rx_mem[rx_wr] = data;
                    rx_wr = ring_next(rx_wr, URB_RX_DEPTH);
                    w.accepted = 1'b1;
                end else begin
                    rx_drops++;
                    if (!flow_stopped) begin
                        void'(tx_push(URB_XOFF));
                        flow_stopped = 1'b1;
                    end
                end
                words.push_back(w);
            end
            OP_PUT: begin
                w.accepted = tx_push(data);
                if (!w.accepted)
                    tx_refusals++;
                words.push_back(w);
            end
            OP_TX_RDY: begin
                if (tx_wr != tx_rd) begin
                    w.byte_valid = 1'b1;
                    w.byte_out = tx_mem[tx_rd];
                    tx_rd = ring_next(tx_rd, URB_TX_DEPTH);
                end else begin
                    tx_active = 1'b0;
                end
                words.push_back(w);
            end
            OP_READ: begin
                while (rx_wr != rx_rd && left != 0) begin
                    w = '0;
                    w.byte_valid = 1'b1;
                    w.byte_out = rx_mem[rx_rd];
                    rx_rd = ring_next(rx_rd, URB_RX_DEPTH);
                    words.push_back(w);
                    left--;
                end
                if (words.size() == 0) begin
                    w = '0;
                    w.last = 1'b1;
                    words.push_back(w);
                end else begin
                    words[words.size() - 1].last = 1'b1;
                    if (flow_stopped) begin
                        flow_stopped = 1'b0;
                        void'(tx_push(URB_XON));
                    end
                end
            end
            OP_CLR_RX: begin
                rx_wr = 0;
                rx_rd = 0;
                words.push_back(w);
            end
            default: words.push_back(w);
        endcase
        foreach (words[i]) begin
            words[i].tx_busy = tx_active;
            expected_words.push_back(words[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (!word_pending) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
                drive_item = pending_ops.pop_front();
                i_opcode <= drive_item.op;
                i_data_in <= drive_item.data;
                i_read_limit <= drive_item.limit;
                i_in_valid <= 1'b1;
                word_pending = 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_op(i_opcode, i_data_in, i_read_limit);
                word_pending = 1'b0;
                ops_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word with nothing expected, byte_out", o_byte_out, 0);
                end else begin
                    want_word = expected_words.pop_front();
                    words_checked++;
                    if (o_accepted !== want_word.accepted)
                        report_mismatch("accepted", o_accepted, want_word.accepted);
                    if (o_byte_valid !== want_word.byte_valid)
                        report_mismatch("byte_valid", o_byte_valid, want_word.byte_valid);
                    if (o_byte_out !== want_word.byte_out)
                        report_mismatch("byte_out", o_byte_out, want_word.byte_out);
                    if (o_last !== want_word.last)
                        report_mismatch("last", o_last, want_word.last);
                    if (o_tx_busy !== want_word.tx_busy)
                        report_mismatch("tx_busy", o_tx_busy, want_word.tx_busy);
                end
            end
        end
    end

    task automatic add_op(input logic [2:0] op, input logic [7:0] data,
                          input logic [7:0] limit);
        t_op_item it;
        it.op = op;
        it.data = data;
        it.limit = limit;
        pending_ops.push_back(it);
    endtask

    task automatic add_burst(input logic [2:0] op, input int len);
        for (int i = 0; i < len; i++)
            add_op(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'hFF;
            2: return 8'($urandom_range(8, 1));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly well-formed traffic: fills past full, drains, reads that restart flow
    task automatic add_random_ops(input int n_items);
        int added;
        int len;
        added = 0;
        while (added < n_items) begin
            case ($urandom_range(9))
                0: begin
                    len = $urandom_range(36, 32);
                    add_op(OP_READ, 8'($urandom_range(255)), pick_limit());
                    add_burst(OP_RX_BYTE, len);
                    add_burst(OP_TX_RDY, 3);
                    added += len + 4;
                end
                1, 2: begin
                    len = $urandom_range(12, 1);
                    add_burst(OP_RX_BYTE, len);
                    added += len;
                end
                3: begin
                    len = $urandom_range(36, 1);
                    add_burst(OP_PUT, len);
                    added += len;
                end
                4, 5: begin
                    len = $urandom_range(20, 1);
                    add_burst(OP_TX_RDY, len);
                    added += len;
                end
                6, 7: begin
                    add_op(OP_READ, 8'($urandom_range(255)), pick_limit());
                    added++;
                end
                8: begin
                    add_op(OP_CLR_RX, 8'($urandom_range(255)), 8'($urandom_range(255)));
                    added++;
                end
                default: begin
                    if ($urandom_range(1))
                        add_op(3'($urandom_range(OP_BAD_HI, OP_BAD_LO)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                    else
                        add_op(3'($urandom_range(7)), 8'($urandom_range(255)),
                               8'($urandom_range(255)));
                    added++;
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || word_pending || expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        rx_wr = 0;
        rx_rd = 0;
        tx_wr = 0;
        tx_rd = 0;
        flow_stopped = 1'b1;
        tx_active = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_op(OP_READ, 8'h00, 8'hFF);
        add_op(OP_TX_RDY, 8'hFF, 8'h00);
        add_op(OP_PUT, 8'h00, 8'hFF);
        add_op(OP_PUT, 8'hFF, 8'h00);
        add_op(OP_TX_RDY, 8'h00, 8'h00);
        add_op(OP_TX_RDY, 8'h00, 8'h00);
        add_op(OP_TX_RDY, 8'h00, 8'h00);
        add_op(OP_RX_BYTE, 8'hFF, 8'hFF);
        add_op(OP_RX_BYTE, 8'h00, 8'h00);
        add_op(OP_RX_BYTE, 8'h5A, 8'h00);
        add_op(OP_READ, 8'hFF, 8'h00);
        add_op(OP_READ, 8'h00, 8'h01);
        add_op(OP_READ, 8'h00, 8'hFF);
        add_op(OP_TX_RDY, 8'h00, 8'h00);
        add_op(OP_TX_RDY, 8'h00, 8'h00);
        add_op(OP_RX_BYTE, 8'hA5, 8'h00);
        add_op(OP_CLR_RX, 8'h00, 8'h00);
        add_op(OP_READ, 8'h00, 8'h04);
        add_op(OP_BAD_LO, 8'hFF, 8'hFF);
        add_op(3'd6, 8'h00, 8'h00);
        add_op(OP_BAD_HI, 8'hFF, 8'hFF);
        wait_drained();

        // pacing: none, sender gaps, receiver stalls, both light
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 67 : (phase == 3) ? 9 : 0;
            stall_pct = (phase == 2) ? 67 : (phase == 3) ? 9 : 0;
            add_random_ops(RANDOM_ITEMS / 4);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        $display("ran %0d ops (rx %0d, put %0d, tx_rdy %0d, read %0d, clr %0d), %0d words",
                 ops_taken, op_count[OP_RX_BYTE], op_count[OP_PUT], op_count[OP_TX_RDY],
                 op_count[OP_READ], op_count[OP_CLR_RX], words_checked);
        $display("rx overflow drops %0d, tx ring refusals %0d, bad opcodes %0d",
                 rx_drops, tx_refusals, op_count[5] + op_count[6] + op_count[7]);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/urb_pkg.sv
rtl/urb_ring.sv
rtl/uart_ring_buffers_xon_xoff.sv
tb/tb_uart_ring_buffers_xon_xoff.sv
